/* rtl/bai_pkg.sv */
// shared types, codes and defaults of the breakpoint automation interpolator
package bai_pkg;

  localparam int NUM_PARAMS_DEF = 8;
  localparam int POINTS_DEF     = 16;
  localparam int DIV_STEPS      = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] REG_INTERP_MODES = 2'd0;

  localparam logic [17:0] SMOOTH_K = 18'd196608;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  param;
    logic [31:0] time_stamp;
    logic [31:0] point_value;
    logic        point_active;
  } item_t;

  typedef struct packed {
    logic        flag;
    logic [31:0] value;
    logic [31:0] time_stamp;
  } entry_t;

endpackage

/* rtl/breakpoint_automation_interpolator.sv */
// top level: configuration register, request front end and list sequencer
//
// channel   dir   handshake           payload
// request   in    in_valid/in_stall   command param_index time_stamp point_value point_active
// result    out   out_valid/out_stall result_value status
// config    in    apb psel/penable    interp_modes at byte address 0
//
// one request at a time in the sequencer; a two-entry queue takes requests ahead
// clear and no-op: the sequencer goes from idle straight to its done state
// insert: a read and a check per entry moved up one slot, then the new point is written
// query: backward and forward scan, serial divider, smoothstep (mode bit 0 only), multiply and add blend
// rst clears the list counts, the mode register and all handshake state
// out_stall holds the result register; the sequencer waits, the queue keeps filling
module breakpoint_automation_interpolator #(
  parameter int NUM_PARAMS       = bai_pkg::NUM_PARAMS_DEF,
  parameter int POINTS_PER_PARAM = bai_pkg::POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [2:0]  param_index,
  input  logic [31:0] time_stamp,
  input  logic [31:0] point_value,
  input  logic        point_active,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result_value,
  output logic        status
);

  logic [15:0]    interp_modes;
  logic           q_valid, q_pop;
  bai_pkg::item_t q_item;

  assign pready = 1'b1;
  assign prdata = (paddr == bai_pkg::REG_INTERP_MODES) ? {16'd0, interp_modes} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_modes <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr == bai_pkg::REG_INTERP_MODES) begin
      interp_modes <= pwdata[15:0];
    end
  end

  bai_front #(.NUM_PARAMS(NUM_PARAMS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .command, .param_index, .time_stamp,
    .point_value, .point_active, .q_valid, .q_item, .q_pop
  );

  bai_back #(.NUM_PARAMS(NUM_PARAMS), .POINTS_PER_PARAM(POINTS_PER_PARAM)) u_back (
    .clk, .rst, .interp_modes, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .result_value, .status
  );

endmodule

/* rtl/bai_front.sv */
// request intake, command classification and two-entry request queue
module bai_front #(
  parameter int NUM_PARAMS = bai_pkg::NUM_PARAMS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     command,
  input  logic [2:0]     param_index,
  input  logic [31:0]    time_stamp,
  input  logic [31:0]    point_value,
  input  logic           point_active,
  output logic           q_valid,
  output bai_pkg::item_t q_item,
  input  logic           q_pop
);

  bai_pkg::item_t slots [2];
  bai_pkg::item_t item_in;
  logic           wp, rp;
  logic [1:0]     fill;
  logic           push;

  always_comb begin
    item_in.param        = param_index;
    item_in.time_stamp   = time_stamp;
    item_in.point_value  = point_value;
    item_in.point_active = point_active;
    priority if ({1'b0, param_index} >= 4'(NUM_PARAMS)) begin
      item_in.op = bai_pkg::OP_NOP;
    end else if (command == bai_pkg::CMD_INSERT) begin
      item_in.op = bai_pkg::OP_INSERT;
    end else if (command == bai_pkg::CMD_QUERY) begin
      item_in.op = bai_pkg::OP_QUERY;
    end else if (command == bai_pkg::CMD_CLEAR) begin
      item_in.op = bai_pkg::OP_CLEAR;
    end else begin
      item_in.op = bai_pkg::OP_NOP;
    end
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= item_in;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* rtl/bai_back.sv */
// breakpoint store, list sequencer, serial divider and blend datapath
module bai_back #(
  parameter int NUM_PARAMS       = bai_pkg::NUM_PARAMS_DEF,
  parameter int POINTS_PER_PARAM = bai_pkg::POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    interp_modes,
  input  logic           q_valid,
  input  bai_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [31:0]    result_value,
  output logic           status
);

  localparam int DEPTH = NUM_PARAMS * POINTS_PER_PARAM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(POINTS_PER_PARAM + 1);
  localparam int PW    = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
  localparam logic [CW-1:0] FULL = CW'(POINTS_PER_PARAM);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_INS_RD  = 13'b0000000000010,
    S_INS_CHK = 13'b0000000000100,
    S_QB_RD   = 13'b0000000001000,
    S_QB_CHK  = 13'b0000000010000,
    S_QF_RD   = 13'b0000000100000,
    S_QF_CHK  = 13'b0000001000000,
    S_DIV     = 13'b0000010000000,
    S_SM1     = 13'b0000100000000,
    S_SM2     = 13'b0001000000000,
    S_MUL     = 13'b0010000000000,
    S_ADD     = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t                state;
  bai_pkg::item_t        cur;
  bai_pkg::entry_t       mem [DEPTH];
  bai_pkg::entry_t       rd_data, wr_data;
  logic                  mem_re, mem_we;
  logic [AW-1:0]         rd_addr, wr_addr, base;
  logic [CW-1:0]         counts [NUM_PARAMS];
  logic [CW-1:0]         idx, cnt_cur;
  logic [PW-1:0]         pidx;
  logic                  have_cur;
  logic [31:0]           t0, v0, v1, den, res;
  logic [32:0]           rem, rem_sh;
  logic [15:0]           quo, f2;
  logic [4:0]            div_cnt;
  logic signed [49:0]    prod;
  logic [33:0]           sm_prod;
  logic [1:0]            mode;
  logic                  st, load_out;

  assign pidx    = cur.param[PW-1:0];
  assign cnt_cur = counts[pidx];
  assign base    = AW'(pidx) * AW'(POINTS_PER_PARAM);
  assign mode    = interp_modes[{cur.param, 1'b0} +: 2];
  assign q_pop   = (state == S_IDLE) && q_valid;
  assign rem_sh  = {rem[31:0], 1'b0};
  assign sm_prod = {18'd0, f2} * {16'd0, bai_pkg::SMOOTH_K - {1'b0, quo, 1'b0}};
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    mem_re  = 1'b0;
    mem_we  = 1'b0;
    rd_addr = base + AW'(idx - CW'(1));
    wr_addr = base + AW'(idx);
    wr_data = '{flag: cur.point_active, value: cur.point_value,
                time_stamp: cur.time_stamp};
    unique case (state)
      S_INS_RD: begin
        mem_re = (idx != '0);
        mem_we = (idx == '0);
      end
      S_INS_CHK: begin
        mem_we = 1'b1;
        if (rd_data.time_stamp >= cur.time_stamp) wr_data = rd_data;
      end
      S_QB_RD: mem_re = (idx != '0);
      S_QF_RD: begin
        mem_re  = (idx != cnt_cur);
        rd_addr = base + AW'(idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (mem_re) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_PARAMS; i++) counts[i] <= '0;
    end else begin
      if (load_out) begin
        out_valid    <= 1'b1;
        result_value <= res;
        status       <= st;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_item;
            res      <= '0;
            st       <= 1'b0;
            have_cur <= 1'b0;
            idx      <= counts[q_item.param[PW-1:0]];
            unique case (q_item.op)
              bai_pkg::OP_INSERT: begin
                if (counts[q_item.param[PW-1:0]] == FULL) begin
                  st    <= 1'b1;
                  state <= S_DONE;
                end else begin
                  state <= S_INS_RD;
                end
              end
              bai_pkg::OP_QUERY: state <= S_QB_RD;
              bai_pkg::OP_CLEAR: begin
                counts[q_item.param[PW-1:0]] <= '0;
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_INS_RD: begin
          if (idx == '0) begin
            counts[pidx] <= cnt_cur + CW'(1);
            state        <= S_DONE;
          end else begin
            state <= S_INS_CHK;
          end
        end
        S_INS_CHK: begin
          if (rd_data.time_stamp >= cur.time_stamp) begin
            idx   <= idx - CW'(1);
            state <= S_INS_RD;
          end else begin
            counts[pidx] <= cnt_cur + CW'(1);
            state        <= S_DONE;
          end
        end
        S_QB_RD: begin
          state <= (idx == '0) ? S_QF_RD : S_QB_CHK;
        end
        S_QB_CHK: begin
          if (rd_data.flag && rd_data.time_stamp <= cur.time_stamp) begin
            have_cur <= 1'b1;
            t0       <= rd_data.time_stamp;
            v0       <= rd_data.value;
            res      <= rd_data.value;
            state    <= (rd_data.time_stamp == cur.time_stamp) ? S_DONE : S_QF_RD;
          end else begin
            idx   <= idx - CW'(1);
            state <= S_QB_RD;
          end
        end
        S_QF_RD: begin
          state <= (idx == cnt_cur) ? S_DONE : S_QF_CHK;
        end
        S_QF_CHK: begin
          if (rd_data.flag) begin
            priority if (!have_cur) begin
              res   <= rd_data.value;
              state <= S_DONE;
            end else if (mode[1] || rd_data.time_stamp <= t0) begin
              state <= S_DONE;
            end else begin
              v1      <= rd_data.value;
              rem     <= {1'b0, cur.time_stamp - t0};
              den     <= rd_data.time_stamp - t0;
              quo     <= '0;
              div_cnt <= '0;
              state   <= S_DIV;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= S_QF_RD;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[14:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[14:0], 1'b0};
          end
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(bai_pkg::DIV_STEPS - 1)) begin
            state <= mode[0] ? S_SM1 : S_MUL;
          end
        end
        S_SM1: begin
          f2    <= 16'(({16'd0, quo} * {16'd0, quo}) >> 16);
          state <= S_SM2;
        end
        S_SM2: begin
          quo   <= (sm_prod[33:16] > 18'd65535) ? 16'hFFFF : sm_prod[31:16];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= $signed({1'b0, quo}) * ($signed({v1[31], v1}) - $signed({v0[31], v0}));
          state <= S_ADD;
        end
        S_ADD: begin
          res   <= v0 + 32'(prod >>> 16);
          state <= S_DONE;
        end
        S_DONE: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == S_IDLE)
    else $error("request taken while sequencer busy");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_cnt < 5'(bai_pkg::DIV_STEPS))
    else $error("divider ran past its steps");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> cnt_cur <= FULL)
    else $error("list count beyond capacity");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result_value))
    else $error("stalled result lost");

endmodule
